### rtl/trqc_pkg.sv
// Package for the task ready queue: queue sizing, command and status codes,
// and the command/status bundles between the controller and the datapath.
// No dependencies.
package trqc_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths of the stream beats
    localparam int CMD_W    = 2;
    localparam int ID_W     = 32;
    localparam int HDL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int CORE_W   = 8;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 72;

    // Idle task id is the core number placed above this bit
    localparam int IDLE_SHIFT = 24;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE     = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the input beat
        logic search;  // register the id match vector
        logic apply;   // update the queue and load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             out_free;  // result register can take a new result
        logic [CNT_W-1:0] occ;       // current occupancy
    } t_dp_stat;

endpackage

### rtl/trqc_ctrl.sv
// Controller for the task ready queue: sequences load, search and apply.
// Depends on trqc_pkg.
module trqc_ctrl
    import trqc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_apply;
    logic       w_load;

    // Apply once the result register is free; take the next beat in that cycle
    assign w_apply    = (r_state == S_APPLY) && i_stat.out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_apply;
    assign w_load     = o_in_ready && i_in_valid;

    assign o_cmd.load   = w_load;
    assign o_cmd.search = (r_state == S_SEARCH);
    assign o_cmd.apply  = w_apply;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_load) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_apply) n_state = w_load ? S_SEARCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/trqc_dpath.sv
// Datapath for the task ready queue: compacting slot cells, occupancy,
// id match vector, core number register and the result register.
// Depends on trqc_pkg.
module trqc_dpath
    import trqc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_cmd_code,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [HDL_W-1:0]    i_handle,
    input  logic                i_cfg_wr_en,
    input  logic [CORE_W-1:0]   i_cfg_wr_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STAT_W-1:0]   o_status,
    output logic [ID_W-1:0]     o_task_id,
    output logic [HDL_W-1:0]    o_handle,
    output logic [COUNT_W-1:0]  o_count
);

    logic [CMD_W-1:0]       r_cmd;
    logic [ID_W-1:0]        r_id;
    logic [HDL_W-1:0]       r_hdl;
    logic [CORE_W-1:0]      r_core;
    logic [CNT_W-1:0]       r_occ;
    logic [CNT_W-1:0]       n_occ;
    logic [QUEUE_DEPTH-1:0] r_match;
    logic [ID_W-1:0]        r_slot_id  [QUEUE_DEPTH];
    logic [HDL_W-1:0]       r_slot_hdl [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_shift;
    logic                   w_found;
    logic                   w_empty;
    logic                   w_full;
    logic                   w_do_add;
    logic                   w_do_del;
    logic                   w_do_take;
    logic [STAT_W-1:0]      w_status;
    logic [ID_W-1:0]        w_rid;
    logic [HDL_W-1:0]       w_rhdl;
    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_status;
    logic [ID_W-1:0]        r_rid;
    logic [HDL_W-1:0]       r_rhdl;
    logic [COUNT_W-1:0]     r_count;

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_code;
            r_id  <= i_task_id;
            r_hdl <= i_handle;
        end
    end

    // Hold the core number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
        end else if (i_cfg_wr_en) begin
            r_core <= i_cfg_wr_data;
        end
    end

    // Compare every occupied slot against the requested id
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_match[i] <= (CNT_W'(i) < r_occ) && (r_slot_id[i] == r_id);
            end
        end
    end

    // Decode the operation and the compaction mask
    always_comb begin
        w_found   = |r_match;
        w_empty   = (r_occ == '0);
        w_full    = (r_occ == CNT_W'(QUEUE_DEPTH));
        w_do_add  = i_cmd.apply && (r_cmd == CMD_ADD) && !w_full;
        w_do_del  = i_cmd.apply && (r_cmd == CMD_DEL) && w_found;
        w_do_take = i_cmd.apply && (r_cmd == CMD_TAKE) && !w_empty;
        // A cell shifts on a take, or on a delete when it sits at or above the newest match
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_shift[i] = w_do_take || (w_do_del && !(|(r_match >> (i + 1))));
        end
        n_occ = r_occ;
        if (w_do_add) begin
            n_occ = r_occ + CNT_W'(1);
        end else if (w_do_del || w_do_take) begin
            n_occ = r_occ - CNT_W'(1);
        end
    end

    // Result fields
    always_comb begin
        w_status = ST_OK;
        w_rid    = '0;
        w_rhdl   = '0;
        case (r_cmd)
            CMD_ADD: begin
                if (w_full) w_status = ST_FULL;
            end
            CMD_DEL: begin
                if (!w_found) w_status = ST_NOTFOUND;
            end
            CMD_TAKE: begin
                if (w_empty) begin
                    w_status = ST_IDLE;
                    w_rid    = {r_core, (IDLE_SHIFT)'(0)};
                end else begin
                    w_rid  = r_slot_id[0];
                    w_rhdl = r_slot_hdl[0];
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Advance occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Slot cells: pull from the upper neighbor, or take a new entry at the tail
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_shift[i] && (i < QUEUE_DEPTH - 1)) begin
                r_slot_id[i]  <= r_slot_id[(i + 1) % QUEUE_DEPTH];
                r_slot_hdl[i] <= r_slot_hdl[(i + 1) % QUEUE_DEPTH];
            end else if (w_do_add && (CNT_W'(i) == r_occ)) begin
                r_slot_id[i]  <= r_id;
                r_slot_hdl[i] <= r_hdl;
            end
        end
    end

    // Result register: load on apply, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_status <= w_status;
            r_rid    <= w_rid;
            r_rhdl   <= w_rhdl;
            r_count  <= COUNT_W'(n_occ);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.occ      = r_occ;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_task_id   = r_rid;
    assign o_handle    = r_rhdl;
    assign o_count     = r_count;

endmodule

### rtl/task_ready_queue_with_cancel_core.sv
// Top level of the task ready queue with cancel by id.
// Depends on trqc_pkg, trqc_ctrl and trqc_dpath.
//
// Usage:
//   The slave stream carries one command per beat: the command code in
//   s_axis_tuser, the task id and entry handle in s_axis_tdata. Each command
//   returns exactly one beat on the master stream: the status code in
//   m_axis_tuser, the task id, handle and queue count in m_axis_tdata.
//   i_cfg_wr_en writes the core number, which forms the idle task id
//   (core number in bits 31:24); write it only while no command is pending.
//   Each command is captured, then searched (all slot ids compared at once
//   and registered), then applied in the update cycle (the slot cells
//   compact in one step and the result register loads); the next beat is
//   accepted in that update cycle.
//   A finished result waits in the output register; the next command is
//   accepted meanwhile and holds in its update cycle until the receiver
//   takes the waiting result.
//   Reset empties the queue and clears the core number; slot contents are
//   not cleared and need no clearing pass.
module task_ready_queue_with_cancel_core
    import trqc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // task_id[31:0], entry_handle[63:32]
    input  logic [CMD_W-1:0]    s_axis_tuser,   // command[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // out_task_id[31:0], out_handle[63:32],
                                                // count[68:64], zero[71:69]
    output logic [STAT_W-1:0]   m_axis_tuser,   // status[1:0]
    input  logic                i_cfg_wr_en,
    input  logic [CORE_W-1:0]   i_cfg_wr_data
);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [ID_W-1:0]    w_out_id;
    logic [HDL_W-1:0]   w_out_hdl;
    logic [COUNT_W-1:0] w_out_count;

    trqc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    trqc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cmd_code    (s_axis_tuser),
        .i_task_id     (s_axis_tdata[ID_W-1:0]),
        .i_handle      (s_axis_tdata[ID_W+HDL_W-1:ID_W]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_task_id     (w_out_id),
        .o_handle      (w_out_hdl),
        .o_count       (w_out_count)
    );

    // Pack the result beat
    assign m_axis_tdata = {(M_DATA_W - ID_W - HDL_W - COUNT_W)'(0),
                           w_out_count, w_out_hdl, w_out_id};

    // Occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // Every update loads a result beat
    a_apply_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |=> m_axis_tvalid)
        else $error("update without result beat");

    // Occupancy changes only in an update cycle
    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.apply |=> $stable(w_stat.occ))
        else $error("occupancy changed outside an update");

    // The idle task is returned only with an empty queue
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_IDLE)) |-> (w_out_count == '0))
        else $error("idle task returned with a nonempty queue");

endmodule
